[rtl/assert_macros.svh]
// Assertion macros for the lidar obstacle steering RTL, used by the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define LOS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define LOS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `LOS_ASSERT(label, clk, rstn, !(cond), msg)

`endif

[rtl/los_pkg.sv]
// Shared types, constants and helpers for the lidar obstacle steering block.
`default_nettype none

package los_pkg;

    localparam int RANGE_W = 16;
    localparam int MIN_W   = 14;
    localparam int PAIR_W  = RANGE_W + 1;
    localparam logic [MIN_W-1:0] RANGE_CAP = 14'd10000;
    localparam int PAIR_MAX = 131070;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE         = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINEAR_SPEED   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGULAR_TRIM   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_DISTANCE = 8'd3;

    localparam logic [15:0] ALERT_RESET = 16'd1200;

    localparam logic [2:0] DEC_FREE        = 3'd0;
    localparam logic [2:0] DEC_VEER_RIGHT  = 3'd1;
    localparam logic [2:0] DEC_VEER_LEFT   = 3'd2;
    localparam logic [2:0] DEC_AVOID_LEFT  = 3'd3;
    localparam logic [2:0] DEC_AVOID_RIGHT = 3'd4;
    localparam logic [2:0] DEC_BOXED_RIGHT = 3'd5;
    localparam logic [2:0] DEC_BOXED_LEFT  = 3'd6;

    typedef struct packed {
        logic               enable;
        logic [7:0]         linear_speed;
        logic signed [7:0]  angular_trim;
        logic [15:0]        alert_distance;
    } cfg_t;

    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        logic signed [7:0] r;
        if (v > 10'sd127) begin
            r = 8'sd127;
        end else if (v < -10'sd128) begin
            r = -8'sd128;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/lidar_obstacle_steering.sv]
// Lidar obstacle steering: one range sample per cycle, one command per enabled scan.
// Throughput: one sample per cycle; s_ready falls only while two scan summaries wait.
// The marked sample's summary passes the queue, then the back's command register.
// The front updates at most one sector minimum and at most one area sum per sample.
// Reset (synchronous, aresetn low): scan state cleared, queue empty, no command pending,
// configuration back to disabled, zero speed and trim, alert distance 1200 mm.
`default_nettype none

module lidar_obstacle_steering
    import los_pkg::*;
#(
    parameter int SCAN_SAMPLES = 720,
    parameter int SECTOR_COUNT = 9
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [RANGE_W-1:0]     s_range_sample,
    input  wire logic                   s_scan_last,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_linear_cmd,
    output logic signed [7:0]           m_angular_cmd,
    output logic [2:0]                  m_decision
);

    localparam int SUM_W = $clog2((SCAN_SAMPLES / 2) * PAIR_MAX + 1);
    localparam int JOB_W = SECTOR_COUNT * MIN_W + 2 * SUM_W;

    cfg_t             cfg_reg, cfg_next;
    logic             job_in_valid, job_in_ready;
    logic             job_out_valid, job_out_ready;
    logic [JOB_W-1:0] job_in_data, job_out_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENABLE:         cfg_next.enable         = cfg_data[0];
                CFG_LINEAR_SPEED:   cfg_next.linear_speed   = cfg_data[7:0];
                CFG_ANGULAR_TRIM:   cfg_next.angular_trim   = cfg_data[7:0];
                CFG_ALERT_DISTANCE: cfg_next.alert_distance = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.linear_speed   <= '0;
            cfg_reg.angular_trim   <= '0;
            cfg_reg.alert_distance <= ALERT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    los_front #(
        .SCAN_SAMPLES (SCAN_SAMPLES),
        .SECTOR_COUNT (SECTOR_COUNT),
        .SUM_W        (SUM_W),
        .JOB_W        (JOB_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .enable         (cfg_reg.enable),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_range_sample (s_range_sample),
        .s_scan_last    (s_scan_last),
        .job_valid      (job_in_valid),
        .job_ready      (job_in_ready),
        .job_data       (job_in_data)
    );

    los_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (job_in_valid),
        .wr_ready (job_in_ready),
        .wr_data  (job_in_data),
        .rd_valid (job_out_valid),
        .rd_ready (job_out_ready),
        .rd_data  (job_out_data)
    );

    los_back #(
        .SECTOR_COUNT (SECTOR_COUNT),
        .SUM_W        (SUM_W),
        .JOB_W        (JOB_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .job_valid     (job_out_valid),
        .job_ready     (job_out_ready),
        .job_data      (job_out_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_linear_cmd  (m_linear_cmd),
        .m_angular_cmd (m_angular_cmd),
        .m_decision    (m_decision)
    );

endmodule

`default_nettype wire

[rtl/los_queue.sv]
// Two-entry queue of scan summaries between the front and back parts.
`default_nettype none
`include "assert_macros.svh"

module los_queue #(
    parameter int WIDTH = 180
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign wr_ready = count_reg < CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `LOS_ASSERT(q_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue count over depth")
    `LOS_ASSERT(q_push_grows, aclk, aresetn, (wr_fire && !rd_fire) |=> (count_reg == $past(count_reg) + 1'b1), "push lost")
    `LOS_ASSERT(q_pop_shrinks, aclk, aresetn, (rd_fire && !wr_fire) |=> (count_reg == $past(count_reg) - 1'b1), "pop lost")
    `LOS_ASSERT_NEVER(q_ptr_split, aclk, aresetn, (count_reg == '0) && (wr_ptr_reg != rd_ptr_reg), "empty queue with split pointers")

endmodule

`default_nettype wire

[rtl/los_front.sv]
// Front part: takes range samples, keeps sector minima and area sums per scan.
`default_nettype none

module los_front
    import los_pkg::*;
#(
    parameter int SCAN_SAMPLES = 720,
    parameter int SECTOR_COUNT = 9,
    parameter int SUM_W        = 26,
    parameter int JOB_W        = 178
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               enable,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [RANGE_W-1:0] s_range_sample,
    input  wire logic               s_scan_last,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output logic [JOB_W-1:0]        job_data
);

    localparam int SECTOR_LEN = SCAN_SAMPLES / SECTOR_COUNT;
    localparam int HALF_SCAN  = SCAN_SAMPLES / 2;
    localparam int POS_W      = $clog2(SCAN_SAMPLES + 1);
    localparam int SEC_W      = $clog2(SECTOR_COUNT + 1);
    localparam int LEN_W      = $clog2(SECTOR_LEN);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SEC_W-1:0]   sec_idx_reg, sec_idx_next;
    logic [LEN_W-1:0]   sec_cnt_reg, sec_cnt_next;
    logic [RANGE_W-1:0] prev_reg, prev_next;
    logic [SUM_W-1:0]   right_reg, right_next;
    logic [SUM_W-1:0]   left_reg, left_next;
    logic [MIN_W-1:0]   min_reg [SECTOR_COUNT];
    logic [MIN_W-1:0]   min_next [SECTOR_COUNT];

    logic               accept, in_scan, paired;
    logic [MIN_W-1:0]   capped;
    logic [PAIR_W-1:0]  pair;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    assign in_scan = pos_reg < POS_W'(SCAN_SAMPLES);
    assign paired  = in_scan && (pos_reg != '0);
    assign capped  = (s_range_sample < RANGE_W'(RANGE_CAP)) ?
                     s_range_sample[MIN_W-1:0] : RANGE_CAP;
    assign pair    = PAIR_W'(prev_reg) + PAIR_W'(s_range_sample);

    assign job_valid = accept && s_scan_last && enable;

    always_comb begin
        pos_next     = pos_reg;
        sec_idx_next = sec_idx_reg;
        sec_cnt_next = sec_cnt_reg;
        prev_next    = prev_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        for (int i = 0; i < SECTOR_COUNT; i++) begin
            min_next[i] = min_reg[i];
            if (accept && in_scan && sec_idx_reg == SEC_W'(i) && capped < min_reg[i]) begin
                min_next[i] = capped;
            end
        end
        if (accept && in_scan) begin
            pos_next  = pos_reg + 1'b1;
            prev_next = s_range_sample;
            if (sec_cnt_reg == LEN_W'(SECTOR_LEN - 1)) begin
                sec_cnt_next = '0;
                if (sec_idx_reg < SEC_W'(SECTOR_COUNT)) begin
                    sec_idx_next = sec_idx_reg + 1'b1;
                end
            end else begin
                sec_cnt_next = sec_cnt_reg + 1'b1;
            end
            if (paired) begin
                if (pos_reg <= POS_W'(HALF_SCAN)) begin
                    right_next = right_reg + SUM_W'(pair);
                end else begin
                    left_next = left_reg + SUM_W'(pair);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SECTOR_COUNT; i++) begin
            job_data[i*MIN_W +: MIN_W] = min_next[i];
        end
        job_data[SECTOR_COUNT*MIN_W +: SUM_W]         = right_next;
        job_data[SECTOR_COUNT*MIN_W + SUM_W +: SUM_W] = left_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_scan_last)) begin
            pos_reg     <= '0;
            sec_idx_reg <= '0;
            sec_cnt_reg <= '0;
            prev_reg    <= '0;
            right_reg   <= '0;
            left_reg    <= '0;
            for (int i = 0; i < SECTOR_COUNT; i++) begin
                min_reg[i] <= RANGE_CAP;
            end
        end else begin
            pos_reg     <= pos_next;
            sec_idx_reg <= sec_idx_next;
            sec_cnt_reg <= sec_cnt_next;
            prev_reg    <= prev_next;
            right_reg   <= right_next;
            left_reg    <= left_next;
            for (int i = 0; i < SECTOR_COUNT; i++) begin
                min_reg[i] <= min_next[i];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/los_back.sv]
// Back part: applies the steering rules to a scan summary and holds the command.
`default_nettype none

module los_back
    import los_pkg::*;
#(
    parameter int SECTOR_COUNT = 9,
    parameter int SUM_W        = 26,
    parameter int JOB_W        = 178
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             job_valid,
    output logic                  job_ready,
    input  wire logic [JOB_W-1:0] job_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_linear_cmd,
    output logic signed [7:0]     m_angular_cmd,
    output logic [2:0]            m_decision
);

    localparam int FRONT = SECTOR_COUNT / 2;
    localparam int PROD_W = 19;

    logic [MIN_W-1:0]   m [SECTOR_COUNT];
    logic [SUM_W-1:0]   right_sum, left_sum;
    logic [15:0]        alert_mm;
    logic [15:0]        front_m, lft, rgt, side_l, side_r;
    logic [PROD_W-1:0]  lft5, rgt5, alert4;
    logic signed [9:0]  trim_ext;
    logic               found;

    logic [7:0]         lin_next;
    logic signed [7:0]  ang_next;
    logic [2:0]         dec_next;

    logic               m_valid_reg, m_valid_next;
    logic [7:0]         lin_reg;
    logic signed [7:0]  ang_reg;
    logic [2:0]         dec_reg;
    logic               take;

    always_comb begin
        for (int i = 0; i < SECTOR_COUNT; i++) begin
            m[i] = job_data[i*MIN_W +: MIN_W];
        end
    end

    assign right_sum = job_data[SECTOR_COUNT*MIN_W +: SUM_W];
    assign left_sum  = job_data[SECTOR_COUNT*MIN_W + SUM_W +: SUM_W];
    assign alert_mm  = cfg.alert_distance;
    assign front_m   = 16'(m[FRONT]);
    assign lft       = 16'(m[FRONT+1]);
    assign rgt       = 16'(m[FRONT-1]);
    assign lft5      = PROD_W'(lft) * PROD_W'(5);
    assign rgt5      = PROD_W'(rgt) * PROD_W'(5);
    assign alert4    = PROD_W'(alert_mm) << 2;
    assign trim_ext  = 10'(cfg.angular_trim);

    always_comb begin
        lin_next = 8'd0;
        ang_next = 8'sd0;
        dec_next = DEC_FREE;
        found    = 1'b0;
        side_l   = '0;
        side_r   = '0;
        if (front_m > alert_mm) begin
            found    = 1'b1;
            lin_next = cfg.linear_speed;
            if (lft5 <= alert4 && rgt >= alert_mm) begin
                ang_next = sat8(trim_ext - 10'sd4);
                dec_next = DEC_VEER_RIGHT;
            end else if (rgt5 <= alert4 && lft >= alert_mm) begin
                ang_next = sat8(trim_ext + 10'sd4);
                dec_next = DEC_VEER_LEFT;
            end else begin
                ang_next = cfg.angular_trim;
                dec_next = DEC_FREE;
            end
        end else begin
            for (int j = 1; j < FRONT; j++) begin
                side_l = 16'(m[FRONT+j]);
                side_r = 16'(m[FRONT-j]);
                if (!found) begin
                    if (side_l >= alert_mm && side_l >= side_r) begin
                        found    = 1'b1;
                        lin_next = 8'd1;
                        ang_next = 8'sd5;
                        dec_next = DEC_AVOID_LEFT;
                    end else if (side_r >= alert_mm && side_r >= side_l) begin
                        found    = 1'b1;
                        lin_next = 8'd1;
                        ang_next = -8'sd5;
                        dec_next = DEC_AVOID_RIGHT;
                    end
                end
            end
        end
        if (!found) begin
            lin_next = 8'd0;
            if (right_sum > left_sum) begin
                ang_next = -8'sd10;
                dec_next = DEC_BOXED_RIGHT;
            end else begin
                ang_next = 8'sd10;
                dec_next = DEC_BOXED_LEFT;
            end
        end
    end

    assign job_ready = !m_valid_reg || m_ready;
    assign take      = job_valid && job_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
            dec_reg <= dec_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_linear_cmd  = lin_reg;
    assign m_angular_cmd = ang_reg;
    assign m_decision    = dec_reg;

endmodule

`default_nettype wire
